// ----- sv/clvt_pkg.sv -----
// ---------------------------------------------------------------------------
// clvt_pkg
// shared types, codes and the dlc byte-count table of the latest value table
// ---------------------------------------------------------------------------
package clvt_pkg;

   localparam int SLOTS_DEFAULT  = 8;
   localparam int BYTES_PER_SLOT = 8;
   localparam int IDENT_W        = 11;
   localparam int LENGTH_W       = 4;
   localparam int PAYLOAD_W      = 8 * BYTES_PER_SLOT;
   localparam int POSITION_W     = 32;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_EXTENDED = 3'd3,
      ST_QUERY    = 3'd4
   } status_type;

   // one slot as it sits in the slot memory
   typedef struct packed {
      logic [IDENT_W-1:0]   ident;
      logic [LENGTH_W-1:0]  length;
      logic [PAYLOAD_W-1:0] bytes;
   } entry_type;

   localparam logic [6:0] DLC_BYTES [16] = '{
      7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
      7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64
   };

   // dlc code to byte count, capped at one slot
   function automatic logic [LENGTH_W-1:0] dlc_count(input logic [3:0] code);
      logic [6:0] count;
      count = DLC_BYTES[code];
      if (count > 7'(BYTES_PER_SLOT)) begin
         return LENGTH_W'(BYTES_PER_SLOT);
      end
      return count[LENGTH_W-1:0];
   endfunction

endpackage

// ----- sv/clvt_ram.sv -----
// ---------------------------------------------------------------------------
// clvt_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module clvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/can_latest_value_table.sv -----
// ---------------------------------------------------------------------------
// can_latest_value_table
// latest payload per standard can identifier, kept in one slot memory
// ---------------------------------------------------------------------------
// path: an extended frame goes from idle straight to done; any other
//   transaction passes scan (skipped while no slot is claimed), apply and done
// throughput: one transaction at a time; the engine takes a new one in idle,
//   which it reenters as the previous result moves to the output register;
//   the linear scan of the slots (one entry read per cycle, claimed slots only) paces it
// reset: clears the fill count, held position, encoder id, state machine and
//   output valid; no clearing pass, unclaimed slots read as empty
module can_latest_value_table #(
   parameter int SLOTS = clvt_pkg::SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic               req_extended_id,
   input  logic [10:0]        req_frame_id,
   input  logic [3:0]         req_dlc_code,
   input  logic [63:0]        req_payload,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [2:0]         rsp_slot_index,
   output logic signed [31:0] rsp_position,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [10:0]        csr_data
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int LW = clvt_pkg::LENGTH_W;
   localparam int PW = clvt_pkg::PAYLOAD_W;
   localparam int EW = $bits(clvt_pkg::entry_type);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_APPLY = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   // control state
   state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;      // slots are claimed in order, a prefix is used
   logic [AW-1:0] addr_ff, addr_in;      // scan read address
   logic          rvalid_ff, rvalid_in;  // read data of ridx_ff is on the ram output
   logic [AW-1:0] ridx_ff, ridx_in;
   logic          hit_ff, hit_in;
   logic [10:0]   enc_ff, enc_in;
   logic [31:0]   held_ff, held_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // transaction payload
   logic                    query_ff, query_in;
   logic [10:0]             key_ff, key_in;
   logic [LW-1:0]           count_ff, count_in;
   logic [PW-1:0]           payload_ff, payload_in;
   logic [AW-1:0]           slot_ff, slot_in;
   clvt_pkg::entry_type     old_ff, old_in;
   clvt_pkg::status_type    res_status_ff, res_status_in;
   logic [2:0]              res_slot_ff, res_slot_in;
   logic signed [31:0]      res_pos_ff, res_pos_in;
   clvt_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [2:0]              rsp_slot_ff, rsp_slot_in;
   logic signed [31:0]      rsp_pos_ff, rsp_pos_in;

   // slot memory ports
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   clvt_pkg::entry_type ram_wdata;
   clvt_pkg::entry_type ram_rdata;
   logic [EW-1:0]       ram_rdata_raw;

   logic          req_take;
   logic          rsp_free;
   logic [CW-1:0] fill_m1;
   logic [AW-1:0] last_idx;
   logic [PW-1:0] merged;

   clvt_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = clvt_pkg::entry_type'(ram_rdata_raw);

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign fill_m1   = fill_ff - CW'(1);
   assign last_idx  = fill_m1[AW-1:0];

   // new bytes below the count, older ones above it (zero for a fresh slot)
   always_comb begin
      for (int k = 0; k < clvt_pkg::BYTES_PER_SLOT; k++) begin
         if (LW'(k) < count_ff) begin
            merged[8*k +: 8] = payload_ff[8*k +: 8];
         end else if (hit_ff) begin
            merged[8*k +: 8] = old_ff.bytes[8*k +: 8];
         end else begin
            merged[8*k +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      addr_in       = addr_ff;
      rvalid_in     = rvalid_ff;
      ridx_in       = ridx_ff;
      hit_in        = hit_ff;
      enc_in        = enc_ff;
      held_in       = held_ff;
      query_in      = query_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      payload_in    = payload_ff;
      slot_in       = slot_ff;
      old_in        = old_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pos_in    = rsp_pos_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff;
      ram_wdata     = '{ident: key_ff, length: count_ff, bytes: merged};

      // the user must send csr writes only while idle; the block itself does not enforce it
      if (csr_valid && csr_ready) begin
         enc_in = csr_data;
      end

      // output register drains independently of the engine
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               query_in   = req_opcode;
               key_in     = req_opcode ? enc_ff : req_frame_id;
               count_in   = clvt_pkg::dlc_count(req_dlc_code);
               payload_in = req_payload;
               hit_in     = 1'b0;
               addr_in    = '0;
               rvalid_in  = 1'b0;
               if (!req_opcode && req_extended_id) begin
                  // extended frame, nothing to look up
                  res_status_in = clvt_pkg::ST_EXTENDED;
                  res_slot_in   = 3'd0;
                  res_pos_in    = '0;
                  state_in      = S_DONE;
               end else if (fill_ff == '0) begin
                  state_in = S_APPLY;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // one read issued per cycle, its data compared in the following cycle
            addr_in   = addr_ff + AW'(1);
            rvalid_in = 1'b1;
            ridx_in   = addr_ff;
            if (rvalid_ff && (ram_rdata.ident == key_ff)) begin
               hit_in   = 1'b1;
               slot_in  = ridx_ff;
               old_in   = ram_rdata;
               state_in = S_APPLY;
            end else if (rvalid_ff && (ridx_ff == last_idx)) begin
               hit_in   = 1'b0;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            res_pos_in  = '0;
            res_slot_in = 3'd0;
            if (query_ff) begin
               // reload only from a slot that carries a full 32-bit count
               if (hit_ff && (old_ff.length >= LW'(4))) begin
                  held_in = old_ff.bytes[31:0];
               end
               res_status_in = clvt_pkg::ST_QUERY;
               res_pos_in    = (hit_ff && (old_ff.length >= LW'(4))) ?
                               signed'(old_ff.bytes[31:0]) : signed'(held_ff);
            end else if (hit_ff) begin
               ram_we        = 1'b1;
               ram_waddr     = slot_ff;
               res_status_in = clvt_pkg::ST_UPDATED;
               res_slot_in   = 3'(slot_ff);
            end else if (fill_ff < CW'(SLOTS)) begin
               // claim the first free slot
               ram_we        = 1'b1;
               ram_waddr     = fill_ff[AW-1:0];
               fill_in       = fill_ff + CW'(1);
               res_status_in = clvt_pkg::ST_INSERTED;
               res_slot_in   = 3'(fill_ff[AW-1:0]);
            end else begin
               res_status_in = clvt_pkg::ST_DROPPED;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_pos_in    = res_pos_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         addr_ff      <= '0;
         rvalid_ff    <= 1'b0;
         ridx_ff      <= '0;
         hit_ff       <= 1'b0;
         enc_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         addr_ff      <= addr_in;
         rvalid_ff    <= rvalid_in;
         ridx_ff      <= ridx_in;
         hit_ff       <= hit_in;
         enc_ff       <= enc_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      key_ff        <= key_in;
      count_ff      <= count_in;
      payload_ff    <= payload_in;
      slot_ff       <= slot_in;
      old_ff        <= old_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_position   = rsp_pos_ff;

   // fill count never runs past the table
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(SLOTS))
      else $error("fill count exceeds slot count");

   // slot memory is written only while applying a frame
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_APPLY) && !query_ff)
      else $error("slot memory written outside apply");

   // an insert claims exactly one new slot
   a_insert_fill: assert property (@(posedge clock) disable iff (reset)
      (ram_we && !hit_ff) |=> (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("insert did not advance fill count");

   // a finished transaction lands in the output register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("result not loaded into output register");

endmodule
